// File: rtl/dtmfg_pkg.sv
// Shared constants, tone table, keypad map and the build-time cosine helper
// for the eight-tone Goertzel DTMF detector. No dependencies.
package dtmfg_pkg;

  localparam int SampleWidth = 16;
  localparam int ThreshWidth = 48;
  localparam int ToneCount   = 8;
  localparam int ToneIdxW    = $clog2(ToneCount);
  localparam int SymWidth    = 7;

  localparam logic [ThreshWidth-1:0] ThreshReset = 48'd107374;  // 1e-4 in Q.30

  // 2*pi in Q.30
  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;

  // Row tones first, then column tones
  localparam int ToneHz [ToneCount] = '{697, 770, 852, 941, 1209, 1336, 1477, 1633};

  // Indexed by {row, col}
  localparam logic [SymWidth-1:0] Keypad [16] = '{
    7'h31, 7'h32, 7'h33, 7'h41,
    7'h34, 7'h35, 7'h36, 7'h42,
    7'h37, 7'h38, 7'h39, 7'h43,
    7'h2A, 7'h30, 7'h23, 7'h44
  };

  function automatic logic [63:0] taylor_mul(input logic [63:0] term, input logic [63:0] x2);
    return (term * x2) >> 30;
  endfunction

  // cos of a Q0.32 turn, Q.30 result; only ever evaluated at elaboration
  function automatic logic signed [31:0] cos_of_turn(input logic [63:0] turn);
    logic [63:0] p;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic neg;
    p   = turn & 64'hFFFF_FFFF;
    neg = 1'b0;
    if (p >= 64'h8000_0000) begin
      p = 64'h1_0000_0000 - p;
    end
    if (p > 64'h4000_0000) begin
      p   = 64'h8000_0000 - p;
      neg = 1'b1;
    end
    x    = (p * TwoPiQ30 + 64'h8000_0000) >> 32;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    term = taylor_mul(term, x2) / 64'd2;   sum = sum - $signed(term);
    term = taylor_mul(term, x2) / 64'd12;  sum = sum + $signed(term);
    term = taylor_mul(term, x2) / 64'd30;  sum = sum - $signed(term);
    term = taylor_mul(term, x2) / 64'd56;  sum = sum + $signed(term);
    term = taylor_mul(term, x2) / 64'd90;  sum = sum - $signed(term);
    term = taylor_mul(term, x2) / 64'd132; sum = sum + $signed(term);
    term = taylor_mul(term, x2) / 64'd182; sum = sum - $signed(term);
    term = taylor_mul(term, x2) / 64'd240; sum = sum + $signed(term);
    term = taylor_mul(term, x2) / 64'd306; sum = sum - $signed(term);
    term = taylor_mul(term, x2) / 64'd380; sum = sum + $signed(term);
    term = taylor_mul(term, x2) / 64'd462; sum = sum - $signed(term);
    term = taylor_mul(term, x2) / 64'd552; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    if (neg) begin
      sum = -sum;
    end
    return sum[31:0];
  endfunction

endpackage

// File: rtl/dtmfg_in_if.sv
// Sample request channel of the DTMF detector: valid/ready plus payload.
// Depends on dtmfg_pkg.
interface dtmfg_in_if
  import dtmfg_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// File: rtl/dtmfg_out_if.sv
// Result request channel of the DTMF detector: valid/ready plus payload.
// Depends on dtmfg_pkg.
interface dtmfg_out_if
  import dtmfg_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SymWidth-1:0] symbol;
  logic                detected;
  logic [1:0]          row_index;
  logic [1:0]          col_index;

  modport source (output valid, output symbol, output detected, output row_index,
                  output col_index, input ready);
  modport sink   (input valid, input symbol, input detected, input row_index,
                  input col_index, output ready);
endinterface

// File: rtl/dtmf_goertzel_detector_unit.sv
// Channel    Dir  Payload                                       Handshake
// in_i       in   sample[15:0] signed, last_sample              valid/ready
// out_o      out  symbol[6:0], detected, row_index, col_index   valid/ready
// cfg        in   cfg_wdata_i[47:0] energy threshold            cfg_we_i, no wait
//
// One shared 34x33 signed multiplier under a small sequencer does all work.
// A sample is accepted, then takes a multiply and an update step per tone; a
// block end adds six energy steps per tone, then S_DONE loads the result.
// in_i.ready is high only while idle. A finished result sits in the output
// register, so samples keep flowing; only a block end waits for it to drain.
// Reset clears delays, counter and threshold (to 1e-4 in Q.30).
// Depends on dtmfg_pkg, dtmfg_in_if and dtmfg_out_if.
module dtmf_goertzel_detector_unit
  import dtmfg_pkg::*;
#(
  parameter int SAMPLE_RATE_HZ = 8000,
  parameter int MAX_BLOCK_LEN  = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dtmfg_in_if.sink               in_i,
  dtmfg_out_if.source            out_o,
  input  logic                   cfg_we_i,
  input  logic [ThreshWidth-1:0] cfg_wdata_i
);

  localparam int CntW = (MAX_BLOCK_LEN > 1) ? $clog2(MAX_BLOCK_LEN) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_UPD   = 4'd2;
  localparam logic [3:0] S_E_T   = 4'd3;
  localparam logic [3:0] S_E_S1  = 4'd4;
  localparam logic [3:0] S_E_S2  = 4'd5;
  localparam logic [3:0] S_E_TS  = 4'd6;
  localparam logic [3:0] S_E_SUM = 4'd7;
  localparam logic [3:0] S_E_CMP = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Coefficient table, cos in Q.30, built at elaboration
  logic signed [31:0] cos_tab [ToneCount];

  for (genvar g = 0; g < ToneCount; g++) begin : g_coef
    localparam logic [63:0] Turn =
      ((64'(ToneHz[g]) << 32) + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ);
    localparam logic signed [31:0] CosQ30 = cos_of_turn(Turn);
    assign cos_tab[g] = CosQ30;
  end

  logic [3:0]                    state_q;
  logic [ToneIdxW-1:0]           k_q;
  logic [CntW-1:0]               cnt_q;
  logic                          blk_end_q;
  logic signed [SampleWidth-1:0] x_q;
  logic [ThreshWidth-1:0]        thresh_q;

  // Delay ring: entry 0 always belongs to tone k_q
  logic signed [31:0] d1_q [ToneCount];
  logic signed [31:0] d2_q [ToneCount];

  logic signed [66:0] prod_q;
  logic signed [66:0] acc_q;
  logic signed [33:0] t_q;
  logic [63:0]        e_q;
  logic [63:0]        best_r_q;
  logic [63:0]        best_c_q;
  logic [1:0]         br_q;
  logic [1:0]         bc_q;

  logic                out_valid_q;
  logic [SymWidth-1:0] symbol_q;
  logic                detected_q;
  logic [1:0]          row_q;
  logic [1:0]          col_q;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_p;

  logic [66:0]        rnd_mag;
  logic [66:0]        rnd_abs;
  logic signed [33:0] t_rnd;
  logic signed [35:0] s0_wide;
  logic signed [31:0] s0_sat;
  logic signed [66:0] e_diff;
  logic [63:0]        e_clamp;
  logic               in_take;
  logic               out_free;
  logic               det;

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      S_E_S1: begin
        mul_a = 34'(d1_q[0]);
        mul_b = 33'(d1_q[0]);
      end
      S_E_S2: begin
        mul_a = 34'(d2_q[0]);
        mul_b = 33'(d2_q[0]);
      end
      S_E_TS: begin
        mul_a = t_q;
        mul_b = 33'(d2_q[0]);
      end
      default: begin
        mul_a = 34'(cos_tab[k_q]);
        mul_b = 33'(d1_q[0]);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // c*s1 / 2^29, rounded half away from zero
  always_comb begin
    rnd_mag = prod_q[66] ? 67'(-prod_q) : 67'(prod_q);
    rnd_abs = (rnd_mag + (67'd1 << 28)) >> 29;
    t_rnd   = prod_q[66] ? -$signed(34'(rnd_abs)) : $signed(34'(rnd_abs));
  end

  always_comb begin
    s0_wide = 36'(x_q) + 36'(t_rnd) - 36'(d2_q[0]);
    if (s0_wide > 36'sh0_7FFF_FFFF) begin
      s0_sat = 32'sh7FFF_FFFF;
    end else if (s0_wide < -36'sh0_8000_0000) begin
      s0_sat = 32'sh8000_0000;
    end else begin
      s0_sat = s0_wide[31:0];
    end
  end

  // s1^2 + s2^2 - t*s2, clamped to the unsigned 64-bit range
  always_comb begin
    e_diff = acc_q - prod_q;
    if (e_diff[66]) begin
      e_clamp = '0;
    end else if (|e_diff[65:64]) begin
      e_clamp = '1;
    end else begin
      e_clamp = e_diff[63:0];
    end
  end

  assign det      = (best_r_q >= 64'(thresh_q)) && (best_c_q >= 64'(thresh_q));
  assign in_take  = in_i.valid && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.symbol    = symbol_q;
  assign out_o.detected  = detected_q;
  assign out_o.row_index = row_q;
  assign out_o.col_index = col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      cnt_q       <= '0;
      blk_end_q   <= 1'b0;
      x_q         <= '0;
      thresh_q    <= ThreshReset;
      prod_q      <= '0;
      acc_q       <= '0;
      t_q         <= '0;
      e_q         <= '0;
      best_r_q    <= '0;
      best_c_q    <= '0;
      br_q        <= '0;
      bc_q        <= '0;
      out_valid_q <= 1'b0;
      symbol_q    <= '0;
      detected_q  <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      for (int i = 0; i < ToneCount; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      // a new result may load in the same cycle as the old one drains
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            x_q       <= in_i.sample;
            blk_end_q <= in_i.last_sample || (cnt_q == CntW'(MAX_BLOCK_LEN - 1));
            cnt_q     <= (in_i.last_sample || (cnt_q == CntW'(MAX_BLOCK_LEN - 1)))
                         ? '0 : cnt_q + 1'b1;
            k_q       <= '0;
            state_q   <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= mul_p;
          state_q <= S_UPD;
        end
        S_UPD: begin
          for (int i = 0; i < ToneCount - 1; i++) begin
            d1_q[i] <= d1_q[i+1];
            d2_q[i] <= d2_q[i+1];
          end
          d1_q[ToneCount-1] <= s0_sat;
          d2_q[ToneCount-1] <= d1_q[0];
          k_q <= k_q + 1'b1;
          if (k_q == ToneIdxW'(ToneCount - 1)) begin
            best_r_q <= '0;
            best_c_q <= '0;
            br_q     <= '0;
            bc_q     <= '0;
            state_q  <= blk_end_q ? S_E_T : S_IDLE;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_E_T: begin
          prod_q  <= mul_p;
          state_q <= S_E_S1;
        end
        S_E_S1: begin
          t_q     <= t_rnd;
          prod_q  <= mul_p;
          state_q <= S_E_S2;
        end
        S_E_S2: begin
          acc_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= S_E_TS;
        end
        S_E_TS: begin
          acc_q   <= acc_q + prod_q;
          prod_q  <= mul_p;
          state_q <= S_E_SUM;
        end
        S_E_SUM: begin
          e_q     <= e_clamp;
          state_q <= S_E_CMP;
        end
        S_E_CMP: begin
          // first strictly largest wins, rows on tones 0-3, columns on 4-7
          if (!k_q[ToneIdxW-1]) begin
            if (e_q > best_r_q) begin
              best_r_q <= e_q;
              br_q     <= k_q[1:0];
            end
          end else begin
            if (e_q > best_c_q) begin
              best_c_q <= e_q;
              bc_q     <= k_q[1:0];
            end
          end
          for (int i = 0; i < ToneCount - 1; i++) begin
            d1_q[i] <= d1_q[i+1];
            d2_q[i] <= d2_q[i+1];
          end
          d1_q[ToneCount-1] <= d1_q[0];
          d2_q[ToneCount-1] <= d2_q[0];
          k_q <= k_q + 1'b1;
          state_q <= (k_q == ToneIdxW'(ToneCount - 1)) ? S_DONE : S_E_T;
        end
        S_DONE: begin
          if (out_free) begin
            symbol_q    <= det ? Keypad[{br_q, bc_q}] : '0;
            detected_q  <= det;
            row_q       <= br_q;
            col_q       <= bc_q;
            for (int i = 0; i < ToneCount; i++) begin
              d1_q[i] <= '0;
              d2_q[i] <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/tb_top.sv
// Self-checking bench for the eight-tone Goertzel DTMF detector: directed rows, then
// random tone, noise and quiet blocks under several energy thresholds, checked by a predictor.
// Depends on dtmfg_pkg, dtmfg_in_if, dtmfg_out_if and dtmf_goertzel_detector_unit.
`timescale 1ns / 1ps

module tb_top;
  import dtmfg_pkg::*;

  typedef longint unsigned u64_t;

  localparam int RateHz      = 8000;
  localparam int BlockCap    = 256;
  localparam int SettleCycles = 120;
  localparam int CycleLimit  = 600000;
  localparam int HoldCycles  = 1000;
  localparam longint SatHi   = 64'sd2147483647;
  localparam longint SatLo   = -64'sd2147483648;
  localparam real Pi         = 3.14159265358979;

  localparam byte KeyChars [16] = '{
    "1", "2", "3", "A",
    "4", "5", "6", "B",
    "7", "8", "9", "C",
    "*", "0", "#", "D"
  };

  typedef enum int {BlkTone, BlkNoise, BlkQuiet} blk_kind_e;

  typedef struct packed {
    logic [SymWidth-1:0] key;
    logic                hit;
    logic [1:0]          row;
    logic [1:0]          col;
  } verdict_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] smp;
    logic                          fin;
    logic                          typed;
    verdict_t                      want;
  } dir_row_t;

  localparam verdict_t NoTone  = '{7'h00, 1'b0, 2'd0, 2'd0};
  localparam verdict_t KeyOne  = '{7'h31, 1'b1, 2'd0, 2'd0};  // '1'
  localparam verdict_t Unknown = '{7'h00, 1'b0, 2'd0, 2'd0};

  localparam int DirRows = 19;
  dir_row_t dir_rows [DirRows] = '{
    '{16'sh0000, 1'b1, 1'b1, NoTone},   // one-sample zero block, all energies zero
    '{16'sh8000, 1'b1, 1'b1, KeyOne},   // single sample: all energies equal, first wins
    '{16'sh7FFF, 1'b1, 1'b1, KeyOne},
    '{16'sh0001, 1'b1, 1'b1, NoTone},   // energy 1, under threshold
    '{16'shFFFF, 1'b1, 1'b1, NoTone},
    '{16'sh7FFF, 1'b0, 1'b0, Unknown},
    '{16'sh8000, 1'b0, 1'b0, Unknown},
    '{16'sh7FFF, 1'b0, 1'b0, Unknown},
    '{16'sh8000, 1'b1, 1'b0, Unknown},
    '{16'sh0000, 1'b0, 1'b0, Unknown},
    '{16'sh0000, 1'b0, 1'b0, Unknown},
    '{16'sh0000, 1'b0, 1'b0, Unknown},
    '{16'sh0000, 1'b1, 1'b1, NoTone},
    '{16'sh5555, 1'b0, 1'b0, Unknown},
    '{16'shAAAA, 1'b0, 1'b0, Unknown},
    '{16'sh7FFF, 1'b0, 1'b0, Unknown},
    '{16'sh8000, 1'b0, 1'b0, Unknown},
    '{16'sh0001, 1'b0, 1'b0, Unknown},
    '{16'shFFFE, 1'b1, 1'b0, Unknown}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [ThreshWidth-1:0] cfg_wdata;

  dtmfg_in_if  in_ch ();
  dtmfg_out_if out_ch ();

  dtmf_goertzel_detector_unit #(
    .SAMPLE_RATE_HZ(RateHz),
    .MAX_BLOCK_LEN (BlockCap)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Predictor state
  int                     tap_one [ToneCount];
  int                     tap_two [ToneCount];
  longint                 coef_q30 [ToneCount];
  logic [ThreshWidth-1:0] thr_mirror;
  int                     blk_count;

  verdict_t verdict_q [$];
  bit       typed_on;
  verdict_t typed_val;

  int          mismatches;
  int unsigned cycle_cnt;
  int          burst_left;
  bit          gaps_on;
  bit          hold_req;
  int          hold_left;
  int          pat_mode;
  int          pat_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cos(2*pi*hz/rate) in Q.30 via a truncating Taylor series on the first quadrant
  function automatic longint coef_for(int hz);
    longint unsigned turn, p, x, x2, term;
    longint          acc;
    bit              neg;
    turn = ((u64_t'(hz) << 32) + u64_t'(RateHz / 2)) / u64_t'(RateHz);
    p   = turn & 64'hFFFF_FFFF;
    neg = 1'b0;
    if (p >= 64'h8000_0000) p = 64'h1_0000_0000 - p;
    if (p > 64'h4000_0000) begin
      p   = 64'h8000_0000 - p;
      neg = 1'b1;
    end
    x    = (p * TwoPiQ30 + 64'h8000_0000) >> 32;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / u64_t'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return neg ? -acc : acc;
  endfunction

  // c*s1 / 2^29, rounded half away from zero
  function automatic longint coef_mix(longint c, int s1);
    longint prod;
    prod = c * longint'(s1);
    if (prod >= 0) return (prod + (64'sd1 <<< 28)) >>> 29;
    return -(((-prod) + (64'sd1 <<< 28)) >>> 29);
  endfunction

  function automatic longint unsigned tone_power(int idx);
    longint          t, mt, ms;
    longint unsigned base, prod;
    logic [64:0]     wide;
    t    = coef_mix(coef_q30[idx], tap_one[idx]);
    base = u64_t'(longint'(tap_one[idx]) * longint'(tap_one[idx]))
         + u64_t'(longint'(tap_two[idx]) * longint'(tap_two[idx]));
    mt   = (t < 0) ? -t : t;
    ms   = (tap_two[idx] < 0) ? -longint'(tap_two[idx]) : longint'(tap_two[idx]);
    prod = u64_t'(mt) * u64_t'(ms);
    if ((t < 0) != (tap_two[idx] < 0)) begin
      wide = {1'b0, base} + {1'b0, prod};
      return wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
    end
    return (base >= prod) ? base - prod : 64'd0;
  endfunction

  function automatic void clear_filters();
    for (int i = 0; i < ToneCount; i++) begin
      tap_one[i] = 0;
      tap_two[i] = 0;
    end
    blk_count = 0;
  endfunction

  // Runs one sample through the eight filters; returns 1 when the block ends
  function automatic bit absorb_sample(input logic signed [SampleWidth-1:0] smp,
                                       input logic fin, output verdict_t v);
    longint          acc;
    longint unsigned best_r, best_c, e_r, e_c;
    int              br, bc;
    v = '0;
    for (int i = 0; i < ToneCount; i++) begin
      acc = longint'(smp) + coef_mix(coef_q30[i], tap_one[i]) - longint'(tap_two[i]);
      if (acc > SatHi) acc = SatHi;
      if (acc < SatLo) acc = SatLo;
      tap_two[i] = tap_one[i];
      tap_one[i] = int'(acc);
    end
    blk_count++;
    if (!fin && blk_count < BlockCap) return 1'b0;
    best_r = 0;
    best_c = 0;
    br     = 0;
    bc     = 0;
    for (int i = 0; i < 4; i++) begin
      e_r = tone_power(i);
      e_c = tone_power(i + 4);
      if (e_r > best_r) begin
        best_r = e_r;
        br     = i;
      end
      if (e_c > best_c) begin
        best_c = e_c;
        bc     = i;
      end
    end
    if (best_r >= thr_mirror && best_c >= thr_mirror) begin
      v.key = KeyChars[br * 4 + bc][SymWidth-1:0];
      v.hit = 1'b1;
    end
    v.row = br[1:0];
    v.col = bc[1:0];
    clear_filters();
    return 1'b1;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Watches both channels at the rising edge
  always @(posedge clk) begin
    verdict_t got, want, calc;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.symbol, out_ch.detected, out_ch.row_index, out_ch.col_index};
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected result sym=%h det=%b row=%0d col=%0d",
                               got.key, got.hit, got.row, got.col));
        end else begin
          want = verdict_q.pop_front();
          if (got.key !== want.key || got.hit !== want.hit || got.row !== want.row ||
              got.col !== want.col) begin
            flag_error($sformatf("result mismatch: sym %h/%h det %b/%b row %0d/%0d col %0d/%0d (exp/got)",
                                 want.key, got.key, want.hit, got.hit, want.row, got.row,
                                 want.col, got.col));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (absorb_sample(in_ch.sample, in_ch.last_sample, calc)) begin
          verdict_q.push_back(typed_on ? typed_val : calc);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result side back-pressure: changing patterns plus one long hold-off on demand
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (pat_left == 0) begin
      pat_mode = $urandom_range(0, 3);
      pat_left = $urandom_range(20, 150);
    end
    pat_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (pat_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (pat_left % 32) < 4;
        default: out_ch.ready <= pat_left[0];
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_sample(logic signed [SampleWidth-1:0] smp, logic fin);
    if (burst_left == 0) begin
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= smp;
    in_ch.last_sample <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_block(blk_kind_e kind, int len, inout int sent);
    int  r, c, v;
    real ar, ac, ph, acc;
    r  = $urandom_range(0, 3);
    c  = $urandom_range(0, 3);
    ar = $itor($urandom_range(300, 16000));
    ac = ($urandom_range(0, 4) == 0) ? 0.0 : $itor($urandom_range(300, 16000));
    ph = $itor($urandom_range(0, 628)) / 100.0;
    for (int n = 0; n < len; n++) begin
      case (kind)
        BlkTone: begin
          acc = ar * $sin(2.0 * Pi * ToneHz[r] * n / RateHz + ph)
              + ac * $sin(2.0 * Pi * ToneHz[4 + c] * n / RateHz)
              + $itor($urandom_range(0, 400)) - 200.0;
          if (acc > 32767.0) acc = 32767.0;
          if (acc < -32768.0) acc = -32768.0;
          v = $rtoi(acc);
        end
        BlkNoise: v = $urandom;
        default:  v = int'($urandom_range(0, 8)) - 4;
      endcase
      send_sample(v[SampleWidth-1:0], n == len - 1);
      sent++;
    end
  endtask

  // Threshold is only changed with the detector idle and nothing outstanding
  task automatic set_threshold(logic [ThreshWidth-1:0] thr);
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= thr;
    thr_mirror = thr;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ThreshWidth-1:0] thr;
    int                     sent, len, pick;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    typed_on          = 1'b0;
    typed_val         = '0;
    mismatches        = 0;
    cycle_cnt         = 0;
    burst_left        = 0;
    gaps_on           = 1'b1;
    hold_req          = 1'b0;
    hold_left         = 0;
    pat_mode          = 0;
    pat_left          = 0;
    for (int i = 0; i < ToneCount; i++) coef_q30[i] = coef_for(ToneHz[i]);
    clear_filters();
    thr_mirror = ThreshReset;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sent = 0;
    foreach (dir_rows[i]) begin
      typed_on  = dir_rows[i].typed;
      typed_val = dir_rows[i].want;
      send_sample(dir_rows[i].smp, dir_rows[i].fin);
    end
    typed_on = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: thr = '0;
        1: thr = '1;
        2: thr = 48'd1 << 30;
        3: thr = ThreshWidth'({$urandom, $urandom} >> $urandom_range(0, 47));
        default: thr = ThreshReset;
      endcase
      set_threshold(thr);
      gaps_on = (ph != 2);
      sent    = 0;
      if (ph == 0) begin
        // hold results back so several block ends pile up and stall the input
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        repeat (5) send_block(BlkTone, 2, sent);
      end
      if (ph == 1 || ph == 3) send_block(BlkTone, BlockCap + $urandom_range(0, 12), sent);
      while (sent < 128) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) len = $urandom_range(1, 8);
        else if (pick < 19) len = $urandom_range(9, 24);
        else len = $urandom_range(25, 64);
        pick = $urandom_range(0, 9);
        send_block(pick < 6 ? BlkTone : (pick < 9 ? BlkNoise : BlkQuiet), len, sent);
      end
    end

    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
